/* rtl/core/gbm_pkg.sv */
package gbm_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W   = 1;
    localparam int PIX_W    = 6;
    localparam int CH_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int BLK_W    = 6;
    localparam int FEAT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths.
    localparam int COORD_W = 7;   // image coordinates and sizes
    localparam int SHIFT_W = 17;  // one minus overlap, Q16, up to 1.0
    localparam int DEN_W   = 22;  // divisor of the shared divider
    localparam int LEN_W   = 23;  // block length, Q7.16
    localparam int KS_W    = 23;  // block index times shift
    localparam int POS_W   = 46;  // block start, Q32
    localparam int AREA_W  = 14;
    localparam int DQ_W    = 40;  // dividend and quotient shift register
    localparam int STEP_W  = 6;

    localparam logic [SHIFT_W-1:0] ONE_Q16 = 17'h10000;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_STORE   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 3'd4;

    typedef struct packed {
        logic [5:0]  grid_rows;
        logic [5:0]  grid_cols;
        logic [15:0] overlap_q16;
        logic [6:0]  image_rows;
        logic [6:0]  image_cols;
    } cfg_t;

    typedef struct packed {
        logic               is_store;
        logic               store_ok;
        logic [CH_W-1:0]    ch;
        logic [PIX_W-1:0]   prow;
        logic [PIX_W-1:0]   pcol;
        logic [VALUE_W-1:0] value;
        logic [BLK_W-1:0]   brow;
        logic [BLK_W-1:0]   bcol;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic in_fin;
    } back_stat_t;

endpackage

/* rtl/core/gbm_if.sv */
// Request channel.
interface gbm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [5:0] pixel_row;
    logic [5:0] pixel_col;
    logic [2:0] channel_index;
    logic signed [31:0] integral_value;
    logic [5:0] block_row;
    logic [5:0] block_col;

    modport source (output valid, func, pixel_row, pixel_col, channel_index,
                    integral_value, block_row, block_col, input ready);
    modport sink (input valid, func, pixel_row, pixel_col, channel_index,
                  integral_value, block_row, block_col, output ready);
endinterface

// Result channel.
interface gbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] feature;
    logic       area_zero;

    modport source (output valid, feature, area_zero, input ready);
    modport sink (input valid, feature, area_zero, output ready);
endinterface

// Configuration write channel.
interface gbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/gbm_fifo.sv */
module gbm_fifo
    import gbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_item_t push_item,
    input  logic        pop,
    output queue_item_t head_item,
    output fifo_stat_t  stat,
    output logic [2:0]  count
);

    localparam int DEPTH = 4;

    queue_item_t entry_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 3'(DEPTH));
    assign stat.empty = (count_reg == 3'd0);
    assign count      = count_reg;

endmodule

/* rtl/core/gbm_front.sv */
module gbm_front
    import gbm_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    gbm_in_if.sink      in_ch,
    gbm_cfg_if.sink     cfg_ch,
    input  fifo_stat_t  q_stat,
    output logic        push,
    output queue_item_t push_item,
    output cfg_t        cfg
);

    cfg_t cfg_reg, cfg_next;
    logic [CH_W:0] ch_wrap;

    // Requests enter whenever the queue has room.
    assign in_ch.ready = !q_stat.full;
    assign push        = in_ch.valid && in_ch.ready;

    // Channel wraps modulo the channel count.
    always_comb
    begin
        ch_wrap = {1'b0, in_ch.channel_index};
        for (int i = 0; i < 8; i++)
        begin
            if (int'(ch_wrap) >= MAX_CHANNELS)
            begin
                ch_wrap = ch_wrap - (CH_W+1)'(MAX_CHANNELS);
            end
        end
    end

    // Classify the request for the back end.
    always_comb
    begin
        push_item.is_store = (in_ch.func == FUNC_STORE);
        push_item.store_ok = (int'(in_ch.pixel_row) < MAX_ROWS)
                          && (int'(in_ch.pixel_col) < MAX_COLS);
        push_item.ch       = ch_wrap[CH_W-1:0];
        push_item.prow     = in_ch.pixel_row;
        push_item.pcol     = in_ch.pixel_col;
        push_item.value    = in_ch.integral_value;
        push_item.brow     = in_ch.block_row;
        push_item.bcol     = in_ch.block_col;
    end

    // Configuration registers.
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_GRID_ROWS:  cfg_next.grid_rows   = cfg_ch.data[5:0];
                CFG_GRID_COLS:  cfg_next.grid_cols   = cfg_ch.data[5:0];
                CFG_OVERLAP:    cfg_next.overlap_q16 = cfg_ch.data;
                CFG_IMAGE_ROWS: cfg_next.image_rows  = cfg_ch.data[6:0];
                CFG_IMAGE_COLS: cfg_next.image_cols  = cfg_ch.data[6:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows   <= 6'd1;
            cfg_reg.grid_cols   <= 6'd1;
            cfg_reg.overlap_q16 <= 16'd0;
            cfg_reg.image_rows  <= 7'd64;
            cfg_reg.image_cols  <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/gbm_back.sv */
module gbm_back
    import gbm_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  fifo_stat_t  q_stat,
    input  queue_item_t head_item,
    output logic        pop,
    gbm_out_if.source   out_ch,
    output back_stat_t  stat
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_POS   = 4'd4;
    localparam logic [3:0] S_SPAN  = 4'd5;
    localparam logic [3:0] S_AREA  = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_MLOAD = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c,
                                                  input logic [CH_W-1:0] ch);
        addr_of = ADDR_W'((int'(r) * MAX_COLS + int'(c)) * MAX_CHANNELS + int'(ch));
    endfunction

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [3:0]         state_reg, state_next;
    logic               ax_reg, ax_next;
    logic               mean_reg, mean_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [BLK_W-1:0]   brow_reg, brow_next;
    logic [BLK_W-1:0]   bcol_reg, bcol_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [KS_W-1:0]    ks_reg, ks_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] top_reg, top_next;
    logic [COORD_W-1:0] bot_reg, bot_next;
    logic [COORD_W-1:0] left_reg, left_next;
    logic [COORD_W-1:0] right_reg, right_next;
    logic [AREA_W-1:0]  area_reg, area_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DQ_W-1:0]    dq_reg, dq_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic [VALUE_W-1:0] sum_reg, sum_next;
    logic               neg_reg, neg_next;
    logic [FEAT_W-1:0]  res_feat_reg, res_feat_next;
    logic               res_zero_reg, res_zero_next;
    logic               out_valid_reg, out_valid_next;
    logic [FEAT_W-1:0]  feat_reg, feat_next;
    logic               zero_reg, zero_next;

    logic [5:0]          gr, gc, g, gm1, kin, k;
    logic [COORD_W-1:0]  rows_c, cols_c, size, lim, dr, dc;
    logic [SHIFT_W-1:0]  shift;
    logic [LEN_W+16-1:0] dividend;
    logic [POS_W:0]      sa, sb;
    logic [DEN_W:0]      trial;
    logic                ge;
    logic [VALUE_W-1:0]  quot, mag;
    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;

    // Effective configuration.
    always_comb
    begin
        gr     = (cfg.grid_rows == 6'd0) ? 6'd1 : cfg.grid_rows;
        gc     = (cfg.grid_cols == 6'd0) ? 6'd1 : cfg.grid_cols;
        rows_c = (cfg.image_rows < 7'd2) ? 7'd2
               : ((int'(cfg.image_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.image_rows);
        cols_c = (cfg.image_cols < 7'd2) ? 7'd2
               : ((int'(cfg.image_cols) > MAX_COLS) ? 7'(MAX_COLS) : cfg.image_cols);
        shift  = ONE_Q16 - {1'b0, cfg.overlap_q16};
        g      = ax_reg ? gc : gr;
        gm1    = g - 6'd1;
        kin    = ax_reg ? bcol_reg : brow_reg;
        k      = (kin > gm1) ? gm1 : kin;
        size   = ax_reg ? cols_c : rows_c;
        lim    = size - 7'd1;
    end

    // Shared datapath terms.
    always_comb
    begin
        dividend = {lim, 32'd0} + (LEN_W+16)'(den_reg >> 1);
        sa       = {1'b0, pos_reg} + (POS_W+1)'(64'h80000000);
        sb       = sa + (POS_W+1)'({len_reg, 16'd0});
        trial    = {rem_reg, dq_reg[DQ_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        quot     = dq_reg[VALUE_W-1:0];
        mag      = sum_reg[VALUE_W-1] ? (~sum_reg + 32'd1) : sum_reg;
        dr       = bot_reg - top_reg;
        dc       = right_reg - left_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        ax_next       = ax_reg;
        mean_next     = mean_reg;
        ch_next       = ch_reg;
        brow_next     = brow_reg;
        bcol_next     = bcol_reg;
        den_next      = den_reg;
        ks_next       = ks_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        area_next     = area_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        step_next     = step_reg;
        rd_cnt_next   = rd_cnt_reg;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        res_feat_next = res_feat_reg;
        res_zero_next = res_zero_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        feat_next     = feat_reg;
        zero_next     = zero_reg;
        pop           = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        waddr         = addr_of(7'(head_item.prow), 7'(head_item.pcol), head_item.ch);
        raddr         = addr_of(top_reg, left_reg, ch_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (head_item.is_store)
                    begin
                        we = head_item.store_ok;
                    end
                    else
                    begin
                        ch_next    = head_item.ch;
                        brow_next  = head_item.brow;
                        bcol_next  = head_item.bcol;
                        ax_next    = 1'b0;
                        mean_next  = 1'b0;
                        state_next = S_PREP;
                    end
                end
            end
            // Grid denominator and block index times shift.
            S_PREP:
            begin
                den_next   = DEN_W'(23'(ONE_Q16) + 23'(gm1) * 23'(shift));
                ks_next    = KS_W'(23'(k) * 23'(shift));
                state_next = S_LOAD;
            end
            // Block length division, quotient below 2^23.
            S_LOAD:
            begin
                rem_next   = DEN_W'(dividend[LEN_W+15:LEN_W]);
                dq_next    = {dividend[LEN_W-1:0], (DQ_W-LEN_W)'(0)};
                step_next  = STEP_W'(LEN_W);
                state_next = S_DIV;
            end
            // One quotient bit per cycle.
            S_DIV:
            begin
                if (step_reg != '0)
                begin
                    rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                    dq_next   = {dq_reg[DQ_W-2:0], ge};
                    step_next = step_reg - STEP_W'(1);
                end
                else if (mean_reg)
                begin
                    res_feat_next = neg_reg ? FEAT_W'(~quot + 32'd1) : quot[FEAT_W-1:0];
                    res_zero_next = 1'b0;
                    state_next    = S_FIN;
                end
                else
                begin
                    len_next   = dq_reg[LEN_W-1:0];
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                pos_next   = POS_W'(POS_W'(ks_reg) * POS_W'(len_reg));
                state_next = S_SPAN;
            end
            // Round both edges and saturate to the last line.
            S_SPAN:
            begin
                if (!ax_reg)
                begin
                    top_next = (sa[POS_W:32] > 15'(lim)) ? lim : sa[38:32];
                    bot_next = (sb[POS_W:32] > 15'(lim)) ? lim : sb[38:32];
                    ax_next    = 1'b1;
                    state_next = S_PREP;
                end
                else
                begin
                    left_next  = (sa[POS_W:32] > 15'(lim)) ? lim : sa[38:32];
                    right_next = (sb[POS_W:32] > 15'(lim)) ? lim : sb[38:32];
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                area_next  = AREA_W'(dr) * AREA_W'(dc);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (area_reg == '0)
                begin
                    res_feat_next = '0;
                    res_zero_next = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    rd_cnt_next = '0;
                    sum_next    = '0;
                    state_next  = S_READ;
                end
            end
            // Corner reads: issue one address, fold in the previous word.
            S_READ:
            begin
                case (rd_cnt_reg)
                    3'd0:    raddr = addr_of(top_reg, left_reg, ch_reg);
                    3'd1:    raddr = addr_of(bot_reg, right_reg, ch_reg);
                    3'd2:    raddr = addr_of(top_reg, right_reg, ch_reg);
                    default: raddr = addr_of(bot_reg, left_reg, ch_reg);
                endcase
                re = (rd_cnt_reg < 3'd4);
                if (rd_cnt_reg == 3'd1 || rd_cnt_reg == 3'd2)
                begin
                    sum_next = sum_reg + rd_data_reg;
                end
                else if (rd_cnt_reg != 3'd0)
                begin
                    sum_next = sum_reg - rd_data_reg;
                end
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = S_MLOAD;
                end
            end
            // Magnitude divided by area, sign restored afterward.
            S_MLOAD:
            begin
                neg_next   = sum_reg[VALUE_W-1];
                rem_next   = '0;
                dq_next    = {mag, (DQ_W-VALUE_W)'(0)};
                den_next   = DEN_W'(area_reg);
                step_next  = STEP_W'(VALUE_W);
                mean_next  = 1'b1;
                state_next = S_DIV;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    feat_next      = res_feat_reg;
                    zero_next      = res_zero_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        mean_reg     <= mean_next;
        ch_reg       <= ch_next;
        brow_reg     <= brow_next;
        bcol_reg     <= bcol_next;
        den_reg      <= den_next;
        ks_reg       <= ks_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        area_reg     <= area_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        step_reg     <= step_next;
        rd_cnt_reg   <= rd_cnt_next;
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        res_feat_reg <= res_feat_next;
        res_zero_reg <= res_zero_next;
        feat_reg     <= feat_next;
        zero_reg     <= zero_next;
    end

    // Integral image store.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= head_item.value;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.feature   = feat_reg;
    assign out_ch.area_zero = zero_reg;
    assign stat.busy        = (state_reg != S_IDLE);
    assign stat.in_fin      = (state_reg == S_FIN);

endmodule

/* rtl/core/grid_block_mean_from_integral_image.sv */
// Grid block mean over a multi-channel integral image. A store transaction
// is written, if its pixel lies inside the store, as the back end takes it
// from the queue. A compute transaction finds the row and the column span
// of its block and the block area and, unless that area is zero, reads the
// four corners and divides. The bit-serial divider is shared by the two
// block-length divisions and the final mean division; the corners are read
// one by one. A four-entry queue separates request intake from execution,
// so requests keep entering while the back end works and while a result
// waits to be taken. The store has no reset; each element must be written
// before a compute transaction reads it.
module grid_block_mean_from_integral_image
    import gbm_pkg::*;
#(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_COLS     = 64,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    gbm_in_if.sink    in_ch,
    gbm_out_if.source out_ch,
    gbm_cfg_if.sink   cfg_ch
);

    cfg_t        cfg;
    fifo_stat_t  q_stat;
    back_stat_t  b_stat;
    queue_item_t push_item, head_item;
    logic        push, pop;
    logic [2:0]  q_count;

    // Request intake and configuration.
    gbm_front #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_ch    (cfg_ch),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    // Queue between intake and execution.
    gbm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat),
        .count     (q_count)
    );

    // Store and feature computation.
    gbm_back #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .out_ch    (out_ch),
        .stat      (b_stat)
    );

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n) q_count <= 3'd4)
        else $error("queue occupancy exceeds its depth");

    // A new result appears only after the back end finished a computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(b_stat.in_fin))
        else $error("result raised without a finished computation");

    // A zero-area result carries a zero feature.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.area_zero) |-> (out_ch.feature == 8'd0))
        else $error("zero-area result with nonzero feature");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != 3'd0))
        else $error("pop from empty queue");

    // A transaction leaves the queue only while the back end is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !b_stat.busy)
        else $error("pop while the back end is busy");

endmodule

/* bench/grid_block_mean_from_integral_image_tb.sv */
`timescale 1ns / 1ps

module grid_block_mean_from_integral_image_tb;
    import gbm_pkg::*;

    typedef enum logic [1:0] {ROW_STORE, ROW_COMPUTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [5:0]       prow;
        logic [5:0]       pcol;
        logic [2:0]       ch;
        logic [31:0]      val;
        logic [5:0]       brow;
        logic [5:0]       bcol;
        logic [2:0]       cfg_idx;
        logic [15:0]      cfg_data;
        bit               typed;
        logic [7:0]       feat;
        logic             az;
    } dir_row_t;

    typedef struct {
        logic [7:0] feat;
        logic       az;
    } mean_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gbm_in_if  in_if();
    gbm_out_if out_if();
    gbm_cfg_if cfg_if();

    grid_block_mean_from_integral_image u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    // Shadow copy of the registers and of the integral store.
    logic [5:0]  grid_rows_q = 6'd1;
    logic [5:0]  grid_cols_q = 6'd1;
    logic [15:0] overlap_q   = 16'd0;
    logic [6:0]  image_rows_q = 7'd64;
    logic [6:0]  image_cols_q = 7'd64;
    logic [31:0] integral_mem [0:32767];
    bit          written [0:32767];

    mean_t    mean_q[$];
    dir_row_t dir_tab[$];
    int       errors = 0;
    int       send_idle = 0;
    int       recv_stall = 0;
    int       hold_reqs = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int mem_index(int r, int c, int ch);
        return (r * 64 + c) * 8 + ch;
    endfunction

    // Block edge length in Q16.16, rounded half up.
    function automatic longint unsigned edge_len(int size, int grid, int shift);
        longint unsigned den = 64'd65536 + longint'(grid - 1) * shift;
        longint unsigned num = longint'(size - 1) << 32;
        return (num + den / 2) / den;
    endfunction

    // Start and end coordinate of block k, saturated to the last row or column.
    function automatic void span(int k, int shift, longint unsigned len, int limit,
                                 output int lo, output int hi);
        longint unsigned pos = longint'(k) * shift * len;
        longint unsigned a = (pos + 64'h8000_0000) >> 32;
        longint unsigned b = (pos + (len << 16) + 64'h8000_0000) >> 32;
        lo = (a > limit) ? limit : int'(a);
        hi = (b > limit) ? limit : int'(b);
    endfunction

    function automatic void block_box(logic [5:0] brow, logic [5:0] bcol,
                                      output int top, output int bot,
                                      output int lft, output int rgt);
        int gr = (grid_rows_q == 0) ? 1 : grid_rows_q;
        int gc = (grid_cols_q == 0) ? 1 : grid_cols_q;
        int rows = (image_rows_q < 2) ? 2 : (image_rows_q > 64) ? 64 : image_rows_q;
        int cols = (image_cols_q < 2) ? 2 : (image_cols_q > 64) ? 64 : image_cols_q;
        int shift = 65536 - overlap_q;
        int r = (brow > gr - 1) ? gr - 1 : brow;
        int c = (bcol > gc - 1) ? gc - 1 : bcol;
        span(r, shift, edge_len(rows, gr, shift), rows - 1, top, bot);
        span(c, shift, edge_len(cols, gc, shift), cols - 1, lft, rgt);
    endfunction

    function automatic mean_t box_mean(logic [5:0] brow, logic [5:0] bcol, logic [2:0] ch);
        int top, bot, lft, rgt, area, q;
        logic [31:0] sum;
        mean_t m;
        block_box(brow, bcol, top, bot, lft, rgt);
        area = (bot - top) * (rgt - lft);
        if (area == 0) begin
            m.feat = 8'd0;
            m.az = 1'b1;
            return m;
        end
        sum = integral_mem[mem_index(top, lft, ch)] + integral_mem[mem_index(bot, rgt, ch)]
            - integral_mem[mem_index(top, rgt, ch)] - integral_mem[mem_index(bot, lft, ch)];
        q = $signed(sum) / area;
        m.feat = q[7:0];
        m.az = 1'b0;
        return m;
    endfunction

    // Offer one request, with random gaps, and predict it once accepted.
    task automatic send_req(logic func, logic [5:0] prow, logic [5:0] pcol, logic [2:0] ch,
                            logic [31:0] val, logic [5:0] brow, logic [5:0] bcol,
                            bit typed = 0, logic [7:0] tfeat = 0, logic taz = 0);
        mean_t m;
        if ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_if.valid <= 1'b1;
        in_if.func <= func;
        in_if.pixel_row <= prow;
        in_if.pixel_col <= pcol;
        in_if.channel_index <= ch;
        in_if.integral_value <= val;
        in_if.block_row <= brow;
        in_if.block_col <= bcol;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        if (func == FUNC_STORE) begin
            integral_mem[mem_index(prow, pcol, ch)] = val;
            written[mem_index(prow, pcol, ch)] = 1'b1;
        end else begin
            m = box_mean(brow, bcol, ch);
            if (typed) begin
                m.feat = tfeat;
                m.az = taz;
            end
            mean_q.push_back(m);
        end
    endtask

    // Store random values at any corner of the box that was never written.
    task automatic fill_corners(logic [5:0] brow, logic [5:0] bcol, logic [2:0] ch,
                                ref int n);
        int top, bot, lft, rgt;
        int rr[4];
        int cc[4];
        block_box(brow, bcol, top, bot, lft, rgt);
        if ((bot - top) * (rgt - lft) == 0) return;
        rr = '{top, bot, top, bot};
        cc = '{lft, rgt, rgt, lft};
        for (int i = 0; i < 4; i++) begin
            if (!written[mem_index(rr[i], cc[i], ch)]) begin
                send_req(FUNC_STORE, rr[i], cc[i], ch, $urandom, $urandom, $urandom);
                n++;
            end
        end
    endtask

    // Wait until every expected mean has come, then let the back end go quiet.
    task automatic drain();
        while (mean_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // One register write; valid is then dropped and the channel left idle before the task returns.
    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_GRID_ROWS:  grid_rows_q = data[5:0];
            CFG_GRID_COLS:  grid_cols_q = data[5:0];
            CFG_OVERLAP:    overlap_q = data;
            CFG_IMAGE_ROWS: image_rows_q = data[6:0];
            CFG_IMAGE_COLS: image_cols_q = data[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= 300;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Compare each result transaction with the oldest expected mean.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (mean_q.size() == 0) begin
                $display("%0t: unexpected result feature=%0d area_zero=%0b",
                         $time, out_if.feature, out_if.area_zero);
                errors++;
            end else begin
                if (out_if.feature !== mean_q[0].feat) begin
                    $display("%0t: feature expected %0d actual %0d",
                             $time, mean_q[0].feat, out_if.feature);
                    errors++;
                end
                if (out_if.area_zero !== mean_q[0].az) begin
                    $display("%0t: area_zero expected %0b actual %0b",
                             $time, mean_q[0].az, out_if.area_zero);
                    errors++;
                end
                void'(mean_q.pop_front());
            end
        end
    end

    initial begin
        int n;
        int gr;
        logic [5:0] br, bc;
        logic [2:0] ch;
        bit held;
        bit paused;

        held = 1'b0;
        paused = 1'b0;
        in_if.valid = 1'b0;
        in_if.func = FUNC_STORE;
        in_if.pixel_row = '0;
        in_if.pixel_col = '0;
        in_if.channel_index = '0;
        in_if.integral_value = '0;
        in_if.block_row = '0;
        in_if.block_col = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_GRID_ROWS;
        cfg_if.data = '0;

        // Directed table; reset setting is one 64x64 block over the whole image.
        dir_tab = '{
            '{ROW_STORE,   0,  0, 7, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,  63, 63, 7, 32'd793800,   0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,   0, 63, 7, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,  63,  0, 7, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 7, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 1, 200, 0},
            '{ROW_COMPUTE, 0,  0, 7, 32'd0,       63, 63, CFG_GRID_ROWS, 0, 1, 200, 0},
            '{ROW_STORE,   0,  0, 0, 32'h7FFFFFFF, 0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,  63, 63, 0, 32'd1,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,   0, 63, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,  63,  0, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,   0,  0, 0, 32'h80000000, 0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_STORE,  63, 63, 0, 32'hFFFFFFFF, 0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 63, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_GRID_COLS, 63, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_ROWS, 2, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_COLS, 2, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 3, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 1, 0, 1},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_OVERLAP, 16'hFFFF, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_GRID_COLS, 0, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_ROWS, 127, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_COLS, 127, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 7, 32'd0,        5,  9, CFG_GRID_ROWS, 0, 1, 200, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_ROWS, 1, 0, 0, 0},
            '{ROW_CFG,     0,  0, 0, 32'd0,        0,  0, CFG_IMAGE_COLS, 1, 0, 0, 0},
            '{ROW_COMPUTE, 0,  0, 5, 32'd0,        0,  0, CFG_GRID_ROWS, 0, 0, 0, 0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        n = 0;
        foreach (dir_tab[i]) begin
            case (dir_tab[i].kind)
                ROW_STORE:
                    send_req(FUNC_STORE, dir_tab[i].prow, dir_tab[i].pcol, dir_tab[i].ch,
                             dir_tab[i].val, 0, 0);
                ROW_COMPUTE: begin
                    fill_corners(dir_tab[i].brow, dir_tab[i].bcol, dir_tab[i].ch, n);
                    send_req(FUNC_COMPUTE, $urandom, $urandom, dir_tab[i].ch, $urandom,
                             dir_tab[i].brow, dir_tab[i].bcol,
                             dir_tab[i].typed, dir_tab[i].feat, dir_tab[i].az);
                end
                default: begin
                    if (dir_tab[i - 1].kind != ROW_CFG) begin
                        in_if.valid <= 1'b0;
                        drain();
                    end
                    cfg_write(dir_tab[i].cfg_idx, dir_tab[i].cfg_data);
                end
            endcase
        end

        // Random part: four idling phases, two register settings each.
        for (int p = 0; p < 4; p++) begin
            send_idle  = (p == 1 || p == 3) ? ((p == 1) ? 73 : 29) : 0;
            recv_stall = (p == 2 || p == 3) ? ((p == 2) ? 73 : 29) : 0;
            for (int s = 0; s < 2; s++) begin
                in_if.valid <= 1'b0;
                drain();
                if (p == 1 && s == 1) begin
                    cfg_write(CFG_GRID_ROWS, 16'd63);
                    cfg_write(CFG_GRID_COLS, 16'd63);
                    cfg_write(CFG_OVERLAP, 16'hFFFF);
                    cfg_write(CFG_IMAGE_ROWS, 16'd64);
                    cfg_write(CFG_IMAGE_COLS, 16'd64);
                end else if (p == 0 && s == 0) begin
                    cfg_write(CFG_GRID_ROWS, 16'd3);
                    cfg_write(CFG_GRID_COLS, 16'd2);
                    cfg_write(CFG_OVERLAP, 16'd0);
                    cfg_write(CFG_IMAGE_ROWS, 16'd8);
                    cfg_write(CFG_IMAGE_COLS, 16'd8);
                end else begin
                    cfg_write(CFG_GRID_ROWS, $urandom);
                    cfg_write(CFG_GRID_COLS, $urandom);
                    cfg_write(CFG_OVERLAP, $urandom);
                    cfg_write(CFG_IMAGE_ROWS, $urandom);
                    cfg_write(CFG_IMAGE_COLS, $urandom);
                end
                n = 0;
                while (n < 80) begin
                    if (p == 2 && s == 0 && n >= 10 && !held) begin
                        held = 1'b1;
                        hold_reqs++;
                    end
                    if (p == 1 && s == 0 && n >= 40 && !paused) begin
                        paused = 1'b1;
                        in_if.valid <= 1'b0;
                        while (mean_q.size() != 0) @(posedge clk);
                        @(posedge clk);
                    end
                    if ($urandom_range(99) < 55) begin
                        ch = $urandom;
                        gr = (grid_rows_q == 0) ? 1 : grid_rows_q;
                        br = $urandom_range(1) ? $urandom_range(gr - 1) : $urandom;
                        gr = (grid_cols_q == 0) ? 1 : grid_cols_q;
                        bc = $urandom_range(1) ? $urandom_range(gr - 1) : $urandom;
                        fill_corners(br, bc, ch, n);
                        send_req(FUNC_COMPUTE, $urandom, $urandom, ch, $urandom, br, bc);
                    end else begin
                        send_req(FUNC_STORE, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                    end
                    n++;
                end
            end
        end

        in_if.valid <= 1'b0;
        drain();
        if (errors == 0 && mean_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (mean_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, mean_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
